@@ src/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, constants and the helper function of the stride prefetch
// predictor: item structs, table entry layout and the confidence machine.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int ADDR_BITS          = 48;
  localparam int DEGREE_BITS        = 5;
  localparam int TABLE_ENTRIES_DEF  = 64;
  localparam int MAX_DEGREE_DEF     = 16;
  localparam logic [DEGREE_BITS-1:0] DEGREE_RESET = DEGREE_BITS'(2);

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [1:0] {
    CONF_INITIAL   = 2'd0,
    CONF_TRANSIENT = 2'd1,
    CONF_STEADY    = 2'd2,
    CONF_NOPRED    = 2'd3
  } conf_t;

  typedef struct packed {
    addr_t miss_address;
    addr_t load_pc;
  } in_item_t;

  typedef struct packed {
    addr_t prefetch_address;
    logic  last_in_run;
  } out_item_t;

  typedef struct packed {
    addr_t pc;
    addr_t last_address;
    addr_t stride;
    conf_t conf;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic calc;
    logic write;
    logic emit;
  } spp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_hit;
    logic scan_done;
    logic predict;
    logic emit_last;
  } spp_sts_t;

  function automatic conf_t next_conf(input conf_t conf, input logic match);
    conf_t res;
    unique case (conf)
      CONF_INITIAL:   res = match ? CONF_STEADY    : CONF_TRANSIENT;
      CONF_TRANSIENT: res = match ? CONF_STEADY    : CONF_NOPRED;
      CONF_STEADY:    res = match ? CONF_STEADY    : CONF_INITIAL;
      CONF_NOPRED:    res = match ? CONF_TRANSIENT : CONF_NOPRED;
      default:        res = CONF_INITIAL;
    endcase
    return res;
  endfunction

endpackage

@@ src/spp_ram.sv @@
// ----------------------------------------------------------------------------
// spp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/spp_ctrl.sv @@
// ----------------------------------------------------------------------------
// spp_ctrl
// Controller of the stride prefetch predictor: sequences the table scan,
// the stride calculation, the table write and the prefetch run.
// ----------------------------------------------------------------------------
module spp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output spp_pkg::spp_cmd_t cmd,
  input  spp_pkg::spp_sts_t sts
);
  import spp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WRITE,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        priority if (sts.scan_hit) begin
          state_nxt = ST_CALC;
        end else if (sts.scan_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = sts.predict ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ src/spp_datapath.sv @@
// ----------------------------------------------------------------------------
// spp_datapath
// Datapath of the stride prefetch predictor: table memory, scan pointer,
// fill count, victim pointer, stride arithmetic and the prefetch generator.
// ----------------------------------------------------------------------------
module spp_datapath #(
  parameter int TABLE_ENTRIES = spp_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_DEGREE    = spp_pkg::MAX_DEGREE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spp_pkg::in_item_t                 in_item,
  input  logic                              cfg_valid,
  input  logic [spp_pkg::DEGREE_BITS-1:0]   cfg_data,
  input  spp_pkg::spp_cmd_t                 cmd,
  output spp_pkg::spp_sts_t                 sts,
  output logic                              out_valid,
  output spp_pkg::out_item_t                out_item
);
  import spp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [DEGREE_BITS-1:0] cfg_r;
  logic [CNT_W-1:0]       fill_r;
  logic [IDX_W-1:0]       victim_r;
  logic [CNT_W-1:0]       scan_k_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   hit_r;
  logic [IDX_W-1:0]       hit_idx_r;
  entry_t                 hit_entry_r;
  addr_t                  addr_r;
  addr_t                  pc_r;
  addr_t                  trained_stride_r;
  conf_t                  new_conf_r;
  logic                   pred_r;
  logic [DEG_W-1:0]       deg_r;
  logic [DEG_W-1:0]       cnt_r;
  addr_t                  run_addr_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [DEG_W-1:0] deg_sat;
  entry_t           rd_entry;
  logic             pc_match;
  logic             scan_more;
  addr_t            calc_stride;
  logic             calc_match;
  addr_t            run_addr_nxt;
  logic [DEG_W-1:0] cnt_nxt;
  logic             table_full;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_entry;

  spp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_entry),
    .raddr (scan_k_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // Degrees above the supported maximum saturate.
  assign deg_sat = (int'(cfg_r) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(cfg_r);

  // Entries fill from index zero upward and are never freed, so every index
  // below the fill count is valid.
  assign scan_more  = (scan_k_r < fill_r);
  assign pc_match   = cmp_vld_r && (rd_entry.pc == pc_r);
  assign table_full = (fill_r == FULL_CNT);

  // A hit on a steady entry with a nonzero degree predicts exactly when the
  // new stride equals the stored one (addr == prev + stride, mod 2^ADDR_BITS).
  assign calc_stride = addr_r - hit_entry_r.last_address;
  assign calc_match  = (calc_stride == hit_entry_r.stride);

  assign run_addr_nxt = run_addr_r + hit_entry_r.stride;
  assign cnt_nxt      = cnt_r + DEG_W'(1);

  assign wr_en = cmd.write;
  always_comb begin
    wr_entry.pc           = pc_r;
    wr_entry.last_address = addr_r;
    if (hit_r) begin
      wr_idx          = hit_idx_r;
      wr_entry.stride = trained_stride_r;
      wr_entry.conf   = new_conf_r;
    end else begin
      wr_idx          = table_full ? victim_r : fill_r[IDX_W-1:0];
      wr_entry.stride = '0;
      wr_entry.conf   = CONF_INITIAL;
    end
  end

  assign sts.scan_hit  = pc_match;
  assign sts.scan_done = !cmp_vld_r && !scan_more;
  assign sts.predict   = pred_r;
  assign sts.emit_last = (cnt_nxt == deg_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= DEGREE_RESET;
      fill_r      <= '0;
      victim_r    <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      pred_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
        pred_r    <= 1'b0;
      end
      if (cmd.scan) begin
        cmp_vld_r <= scan_more;
        if (pc_match) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.calc) begin
        pred_r <= (hit_entry_r.conf == CONF_STEADY) && calc_match && (deg_r != '0);
      end
      if (cmd.write && !hit_r) begin
        if (table_full) begin
          victim_r <= (victim_r == LAST_IDX) ? '0 : victim_r + IDX_W'(1);
        end else begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r     <= in_item.miss_address;
      pc_r       <= in_item.load_pc;
      run_addr_r <= in_item.miss_address;
      scan_k_r   <= '0;
      cnt_r      <= '0;
      deg_r      <= deg_sat;
    end
    if (cmd.scan) begin
      if (scan_more) begin
        scan_k_r <= scan_k_r + CNT_W'(1);
      end
      cmp_idx_r <= scan_k_r[IDX_W-1:0];
      if (pc_match) begin
        hit_idx_r   <= cmp_idx_r;
        hit_entry_r <= rd_entry;
      end
    end
    if (cmd.calc) begin
      trained_stride_r <= calc_stride;
      new_conf_r       <= next_conf(hit_entry_r.conf, calc_match);
    end
    if (cmd.emit) begin
      run_addr_r                  <= run_addr_nxt;
      cnt_r                       <= cnt_nxt;
      out_item_r.prefetch_address <= run_addr_nxt;
      out_item_r.last_in_run      <= (cnt_nxt == deg_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ src/stride_prefetch_predictor.sv @@
// ----------------------------------------------------------------------------
// stride_prefetch_predictor
// Reference prediction table stride prefetcher: per load PC it tracks the
// last miss address, stride and confidence, and issues a run of prefetch
// addresses on a confident stride match.
//
//   channel | ports                         | handshake
//   --------+-------------------------------+------------------------------
//   input   | start, busy, in_item          | taken when start && !busy
//   result  | out_valid, out_item           | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_data| written when valid && ready
//
// An item goes through a table scan and a table write, with a stride
// calculation between them on a hit and, on a confident stride match, a run
// of D prefetch addresses after them, where D is the prefetch degree; the
// table is scanned one entry per cycle through the single read port of the
// table RAM, and results leave one per cycle.
// After reset the table is empty, the degree is 2 and the victim pointer is 0.
// The receiver cannot stall; results are shown for exactly one cycle.
// ----------------------------------------------------------------------------
module stride_prefetch_predictor #(
  parameter int TABLE_ENTRIES = spp_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_DEGREE    = spp_pkg::MAX_DEGREE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  spp_pkg::in_item_t               in_item,
  output logic                            out_valid,
  output spp_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spp_pkg::DEGREE_BITS-1:0] cfg_data
);
  import spp_pkg::*;

  spp_cmd_t cmd;
  spp_sts_t sts;

  assign cfg_ready = 1'b1;

  spp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  spp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_DEGREE    (MAX_DEGREE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ src/spp_checker.sv @@
// ----------------------------------------------------------------------------
// spp_checker
// Port-level checks of the stride prefetch predictor, bound to the top level.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input spp_pkg::out_item_t out_item
);

  // An accepted item always raises busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted item");

  // Results only come out of work started on an earlier item.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  // A run of prefetch addresses is contiguous up to its marked last item.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_in_run |=> out_valid)
    else $error("prefetch run broken before its last item");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind stride_prefetch_predictor spp_checker u_spp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ tb/sv/stride_prefetch_predictor_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stride_prefetch_predictor_tb
// Self-checking bench for the stride prefetch predictor. A local copy of the
// prediction table is trained on every accepted miss. The prefetch runs that
// it predicts are compared in order with the strobed results. The stimulus
// walks the confidence machine, address wrap, degrees from zero to above the cap
// and table eviction, and then runs random strided streams mixed with noise.
// ----------------------------------------------------------------------------
module stride_prefetch_predictor_tb;
  import spp_pkg::*;

  localparam int NUM_ENTRIES   = TABLE_ENTRIES_DEF;
  localparam int DEGREE_CAP    = MAX_DEGREE_DEF;
  localparam int IDLE_PCT      = 18;
  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int NUM_STREAMS   = 10;
  localparam int TIMEOUT_NS    = 5_000_000;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  logic                   busy;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DEGREE_BITS-1:0] cfg_data  = '0;

  // Local copy of the prediction table.
  logic                   rpt_valid  [NUM_ENTRIES];
  addr_t                  rpt_pc     [NUM_ENTRIES];
  addr_t                  rpt_last   [NUM_ENTRIES];
  addr_t                  rpt_stride [NUM_ENTRIES];
  conf_t                  rpt_conf   [NUM_ENTRIES];
  int                     rpt_victim;
  logic [DEGREE_BITS-1:0] rpt_degree;

  in_item_t  pending_misses[$];
  out_item_t expected_prefetches[$];
  out_item_t want_prefetch;
  int        accepted_count = 0;
  int        error_count    = 0;

  // Stream generator state for the random part.
  addr_t stream_pc     [NUM_STREAMS];
  addr_t stream_next   [NUM_STREAMS];
  addr_t stream_stride [NUM_STREAMS];

  stride_prefetch_predictor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Looks up the miss, queues the prefetch run it causes and trains the entry.
  function automatic void train_and_predict(input in_item_t miss);
    int        hit;
    int        free_slot;
    int        slot;
    int        run_len;
    addr_t     prev;
    addr_t     stride;
    addr_t     stride_delta;
    addr_t     next_addr;
    logic      match;
    out_item_t pf;
    hit = -1;
    free_slot = -1;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      if (rpt_valid[k]) begin
        if (hit < 0 && rpt_pc[k] == miss.load_pc) hit = k;
      end else if (free_slot < 0) begin
        free_slot = k;
      end
    end
    if (hit >= 0) begin
      prev = rpt_last[hit];
      stride = rpt_stride[hit];
      stride_delta = addr_t'(miss.miss_address - prev);
      match = (stride_delta == stride);
      if (rpt_conf[hit] == CONF_STEADY && miss.miss_address == addr_t'(prev + stride)) begin
        run_len = (rpt_degree > DEGREE_CAP) ? DEGREE_CAP : int'(rpt_degree);
        next_addr = miss.miss_address;
        for (int i = 1; i <= run_len; i++) begin
          next_addr = addr_t'(next_addr + stride);
          pf.prefetch_address = next_addr;
          pf.last_in_run = (i == run_len);
          expected_prefetches = {expected_prefetches, pf};
        end
      end
      case (rpt_conf[hit])
        CONF_INITIAL:   rpt_conf[hit] = match ? CONF_STEADY : CONF_TRANSIENT;
        CONF_TRANSIENT: rpt_conf[hit] = match ? CONF_STEADY : CONF_NOPRED;
        CONF_STEADY:    rpt_conf[hit] = match ? CONF_STEADY : CONF_INITIAL;
        default:        rpt_conf[hit] = match ? CONF_TRANSIENT : CONF_NOPRED;
      endcase
      rpt_stride[hit] = stride_delta;
      rpt_last[hit] = miss.miss_address;
    end else begin
      if (free_slot >= 0) begin
        slot = free_slot;
      end else begin
        slot = rpt_victim;
        rpt_victim = (slot + 1) % NUM_ENTRIES;
      end
      rpt_valid[slot] = 1'b1;
      rpt_pc[slot] = miss.load_pc;
      rpt_last[slot] = miss.miss_address;
      rpt_stride[slot] = '0;
      rpt_conf[slot] = CONF_INITIAL;
    end
  endfunction

  // Miss driver: trains the local table on each accepted item.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        train_and_predict(in_item);
        void'(pending_misses.pop_front());
        accepted_count++;
      end
      // A window of items goes through with no idle cycles at all.
      if (pending_misses.size() != 0 &&
          ((accepted_count >= 150 && accepted_count < 210) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        start <= 1'b1;
        in_item <= pending_misses[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Prefetch monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_prefetches.size() == 0) begin
        report_mismatch($sformatf("unexpected prefetch %h", out_item.prefetch_address));
      end else begin
        want_prefetch = expected_prefetches.pop_front();
        if (out_item.prefetch_address !== want_prefetch.prefetch_address)
          report_mismatch($sformatf("prefetch_address %h, expected %h",
                                    out_item.prefetch_address,
                                    want_prefetch.prefetch_address));
        if (out_item.last_in_run !== want_prefetch.last_in_run)
          report_mismatch($sformatf("last_in_run %b, expected %b at %h",
                                    out_item.last_in_run, want_prefetch.last_in_run,
                                    want_prefetch.prefetch_address));
      end
    end
  end

  function automatic addr_t rand_addr();
    return addr_t'({$urandom(), $urandom()});
  endfunction

  function automatic addr_t pick_stride();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return addr_t'(8 * $urandom_range(1, 64));
      6, 7:             return addr_t'(-(8 * $urandom_range(1, 64)));
      8:                return '0;
      default:          return rand_addr();
    endcase
  endfunction

  task automatic push_miss(input addr_t addr, input addr_t pc);
    in_item_t m;
    m.miss_address = addr;
    m.load_pc = pc;
    pending_misses = {pending_misses, m};
  endtask

  task automatic push_run(input addr_t pc, input addr_t base, input addr_t stride,
                          input int count);
    for (int i = 0; i < count; i++) push_miss(addr_t'(base + i * stride), pc);
  endtask

  // Waits until every item is taken and every prefetch has come out, then
  // lets a miss that emits nothing finish its table scan.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_misses.size() != 0 || expected_prefetches.size() != 0 || start);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_degree(input logic [DEGREE_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    rpt_degree = value;
  endtask

  // Strided streams with occasional stride changes, skipped addresses and
  // unrelated misses that keep the table churning.
  task automatic push_random(input int count);
    int r;
    int s;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        push_miss(rand_addr(), rand_addr());
      end else begin
        s = $urandom_range(NUM_STREAMS - 1);
        if (r < 20) stream_stride[s] = pick_stride();
        else if (r < 24) stream_next[s] = addr_t'(stream_next[s] + stream_stride[s]);
        push_miss(stream_next[s], stream_pc[s]);
        stream_next[s] = addr_t'(stream_next[s] + stream_stride[s]);
      end
    end
  endtask

  initial begin
    int guard;
    for (int k = 0; k < NUM_ENTRIES; k++) rpt_valid[k] = 1'b0;
    rpt_victim = 0;
    rpt_degree = DEGREE_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset degree: allocate, go transient, steady, then predict.
    push_run('0, 48'h100, 48'h40, 4);
    push_miss('1, '0);
    // Negative stride that wraps below zero.
    push_run('1, 48'h20, addr_t'(-16), 4);
    // Through no-prediction and back up to steady, then lose the stride.
    push_miss(48'h1000, 48'h5555_5555_5555);
    push_miss(48'h1008, 48'h5555_5555_5555);
    push_run(48'h5555_5555_5555, 48'h1100, 48'h100, 5);
    push_miss(48'h1700, 48'h5555_5555_5555);
    wait_idle();

    // Degree zero still trains the entry up to steady.
    write_degree(0);
    push_run(48'hAAAA_AAAA_AAAA, 48'h8000, 48'h40, 5);
    wait_idle();
    // Degrees above the cap saturate.
    write_degree(31);
    push_miss(48'h8140, 48'hAAAA_AAAA_AAAA);
    wait_idle();
    write_degree(1);
    push_miss(48'h8180, 48'hAAAA_AAAA_AAAA);
    wait_idle();
    write_degree(16);
    push_miss(48'h81C0, 48'hAAAA_AAAA_AAAA);
    wait_idle();
    write_degree(17);
    push_miss(48'h8200, 48'hAAAA_AAAA_AAAA);
    wait_idle();

    // Overfill the table so that round-robin eviction kicks in.
    write_degree(DEGREE_BITS'($urandom_range(1, DEGREE_CAP)));
    for (int i = 0; i < NUM_ENTRIES + 6; i++) push_miss(rand_addr(), rand_addr());
    wait_idle();

    for (int s = 0; s < NUM_STREAMS; s++) begin
      stream_pc[s] = rand_addr();
      stream_next[s] = rand_addr();
      stream_stride[s] = pick_stride();
    end
    for (int p = 0; p < 5; p++) begin
      if ($urandom_range(3) == 0) write_degree(DEGREE_BITS'($urandom_range(31)));
      else write_degree(DEGREE_BITS'($urandom_range(1, DEGREE_CAP)));
      push_random(30);
      if (p < 4) wait_idle();
    end

    do @(negedge clk);
    while (pending_misses.size() != 0 || start);
    guard = 0;
    while (expected_prefetches.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_prefetches.size() != 0)
      report_mismatch($sformatf("%0d prefetches never issued", expected_prefetches.size()));

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ stride_prefetch_predictor.f @@
src/spp_pkg.sv
src/spp_ram.sv
src/spp_ctrl.sv
src/spp_datapath.sv
src/stride_prefetch_predictor.sv
src/spp_checker.sv
tb/sv/stride_prefetch_predictor_tb.sv
